// File: design/iig_pkg.sv
// shared constants, types and size helpers for the integral image generator
package iig_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int NUM_CH = 3;
  localparam int PIX_W  = 8;
  localparam int RUN_W  = 18;
  localparam int SUM_W  = 28;
  localparam int SIZE_W = 11;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  // compare width for position + 1 against a clamped size
  localparam int CMP_W = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;

  localparam int LINE_W = NUM_CH * SUM_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd480;

  // output queue
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [RUN_W-1:0] run_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_vec_t;
  typedef logic [NUM_CH-1:0][RUN_W-1:0] run_vec_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] line_t;

  // item between the scan stage and the line-store update stage
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic             top_row;
    run_vec_t         run;
    logic             last;
  } scan_t;

  // one finished result
  typedef struct packed {
    line_t sum;
    logic  last;
  } result_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CMP_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] lim;
    ext = CMP_W'(v);
    lim = CMP_W'(maxv);
    if (ext == '0) begin
      return CMP_W'(1);
    end else if (ext > lim) begin
      return lim;
    end
    return ext;
  endfunction

endpackage

// File: design/integral_image_generator.sv
// top level of the three-channel integral image (summed-area table) generator
//
//   channel   handshake              payload                          dir
//   -------   --------------------   ------------------------------   ---
//   in        in_valid / in_stall    chan0 chan1 chan2 frame_start    in
//   out       out_valid / out_stall  sum0 sum1 sum2 frame_last        out
//   cfg       cfg_valid / cfg_ready  cfg_index cfg_data               in
//
// one pixel per clock while in_stall is low; a result is offered once it has passed the scan
// register with the line-store read and then the result queue
// the line-store ram port pair (one read, one write per cycle) sets that rate
// rst is synchronous; it clears position, row sums, queue and config to defaults
// in_stall rises only while the result queue cannot take what is in flight
// cfg_ready is always high; writes belong to idle periods between frames
module integral_image_generator (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [iig_pkg::PIX_W-1:0]       chan0,
  input  logic [iig_pkg::PIX_W-1:0]       chan1,
  input  logic [iig_pkg::PIX_W-1:0]       chan2,
  input  logic                            frame_start,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iig_pkg::SUM_W-1:0]       sum0,
  output logic [iig_pkg::SUM_W-1:0]       sum1,
  output logic [iig_pkg::SUM_W-1:0]       sum2,
  output logic                            frame_last,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iig_pkg::SIZE_W-1:0]      cfg_data
);

  // configuration registers
  logic [iig_pkg::SIZE_W-1:0] frame_width;
  logic [iig_pkg::SIZE_W-1:0] frame_height;
  logic [iig_pkg::CMP_W-1:0]  width_lim;
  logic [iig_pkg::CMP_W-1:0]  height_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= iig_pkg::FRAME_WIDTH_RESET;
      frame_height <= iig_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iig_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        iig_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_lim  = iig_pkg::clamp_size(frame_width, iig_pkg::MAX_WIDTH);
  assign height_lim = iig_pkg::clamp_size(frame_height, iig_pkg::MAX_HEIGHT);

  // input transfer and flow control
  logic                          accept;
  logic [iig_pkg::QCNT_W-1:0]    q_count;
  iig_pkg::scan_t                stage;
  logic [iig_pkg::QCNT_W:0]      in_flight;

  // queue entries plus the item in the update stage must leave room for one more
  assign in_flight = (iig_pkg::QCNT_W + 1)'(q_count) + (iig_pkg::QCNT_W + 1)'(stage.valid);
  assign in_stall  = in_flight >= (iig_pkg::QCNT_W + 1)'(iig_pkg::QUEUE_DEPTH);
  assign accept    = in_valid && !in_stall;

  // stage one: position, row sums, line-store read
  logic [iig_pkg::COL_W-1:0] rd_addr;

  iig_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pix        ({chan2, chan1, chan0}),
    .frame_start(frame_start),
    .width_lim  (width_lim),
    .height_lim (height_lim),
    .rd_addr    (rd_addr),
    .stage      (stage)
  );

  // line store: previous row's integral values for all channels at one column
  iig_pkg::line_t line_rd;
  iig_pkg::line_t line_wr;

  iig_ram #(
    .WIDTH(iig_pkg::LINE_W),
    .DEPTH(iig_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (stage.valid),
    .waddr(stage.col),
    .wdata(line_wr),
    .raddr(rd_addr),
    .rdata(line_rd)
  );

  // same-column read during the write (single-column frames) is forwarded
  logic           fwd_hit;
  iig_pkg::line_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= accept && stage.valid && (stage.col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= line_wr;
  end

  // stage two: add the value above to the row sum, write back, queue the result
  iig_pkg::line_t above;

  always_comb begin
    above = fwd_hit ? fwd_data : line_rd;
    for (int c = 0; c < iig_pkg::NUM_CH; c++) begin
      // first row of a frame has nothing above it
      line_wr[c] = iig_pkg::SUM_W'(stage.run[c]) + (stage.top_row ? '0 : above[c]);
    end
  end

  iig_pkg::result_t push_data;
  iig_pkg::result_t head;

  assign push_data.sum  = line_wr;
  assign push_data.last = stage.last;

  iig_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (stage.valid),
    .push_data(push_data),
    .pop      (!out_stall),
    .not_empty(out_valid),
    .head     (head),
    .count    (q_count)
  );

  assign sum0       = head.sum[0];
  assign sum1       = head.sum[1];
  assign sum2       = head.sum[2];
  assign frame_last = head.last;

endmodule

// File: design/iig_ram.sv
// generic simple dual-port ram with registered read
module iig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/iig_scan.sv
// raster position counters and per-channel row sums, issues the line-store read
module iig_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  iig_pkg::pix_vec_t           pix,
  input  logic                        frame_start,
  input  logic [iig_pkg::CMP_W-1:0]   width_lim,
  input  logic [iig_pkg::CMP_W-1:0]   height_lim,
  output logic [iig_pkg::COL_W-1:0]   rd_addr,
  output iig_pkg::scan_t              stage
);

  logic [iig_pkg::COL_W-1:0] column_pos;
  logic [iig_pkg::ROW_W-1:0] row_pos;
  iig_pkg::run_vec_t         row_run;

  logic [iig_pkg::COL_W-1:0] col;
  logic [iig_pkg::ROW_W-1:0] row;
  iig_pkg::run_vec_t         row_run_next;
  logic                      row_end;
  logic                      frame_end;

  always_comb begin
    col = frame_start ? '0 : column_pos;
    row = frame_start ? '0 : row_pos;
    for (int c = 0; c < iig_pkg::NUM_CH; c++) begin
      row_run_next[c] = ((col == '0) ? '0 : row_run[c])
                        + iig_pkg::RUN_W'(pix[c]);
    end
    row_end   = (iig_pkg::CMP_W'(col) + iig_pkg::CMP_W'(1)) >= width_lim;
    frame_end = row_end
                && ((iig_pkg::CMP_W'(row) + iig_pkg::CMP_W'(1)) >= height_lim);
  end

  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos  <= '0;
      row_pos     <= '0;
      row_run     <= '0;
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept;
      if (accept) begin
        row_run <= row_run_next;
        if (row_end) begin
          column_pos <= '0;
          row_pos    <= frame_end ? '0 : row + iig_pkg::ROW_W'(1);
        end else begin
          column_pos <= col + iig_pkg::COL_W'(1);
          row_pos    <= row;
        end
      end
    end
    // payload of the stage register
    if (accept) begin
      stage.col     <= col;
      stage.top_row <= (row == '0);
      stage.run     <= row_run_next;
      stage.last    <= frame_end;
    end
  end

endmodule

// File: design/iig_queue.sv
// small result queue that decouples the pipeline from the output stall
module iig_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  iig_pkg::result_t             push_data,
  input  logic                         pop,
  output logic                         not_empty,
  output iig_pkg::result_t             head,
  output logic [iig_pkg::QCNT_W-1:0]   count
);

  iig_pkg::result_t           entry [iig_pkg::QUEUE_DEPTH];
  logic [iig_pkg::QPTR_W-1:0] wr_ptr;
  logic [iig_pkg::QPTR_W-1:0] rd_ptr;
  logic                       do_pop;

  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];
  assign do_pop    = pop && not_empty;

  function automatic logic [iig_pkg::QPTR_W-1:0] ptr_inc(logic [iig_pkg::QPTR_W-1:0] p);
    if (p == iig_pkg::QPTR_W'(iig_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + iig_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + iig_pkg::QCNT_W'(1);
        2'b01:   count <= count - iig_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sim/tb_integral_image_generator.sv
// self-checking testbench for the three-channel integral image generator
`timescale 1ns / 1ps

module tb_integral_image_generator;

  // a result leaves through the scan register and the result queue; leave some margin on top
  localparam int SETTLE_CYCLES  = 8;
  // cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // length of the long receiver hold-off that fills the block up
  localparam int HOLD_CYCLES    = 150;

  // one step of the directed plan: either a register write or a pixel
  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t                     kind;
    logic [iig_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [iig_pkg::SIZE_W-1:0]     reg_val;
    iig_pkg::pix_vec_t              px;
    logic                           fs;
    logic                           typed;
    iig_pkg::result_t               want;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [iig_pkg::PIX_W-1:0]      chan0       = '0;
  logic [iig_pkg::PIX_W-1:0]      chan1       = '0;
  logic [iig_pkg::PIX_W-1:0]      chan2       = '0;
  logic                           frame_start = 1'b0;

  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [iig_pkg::SUM_W-1:0]      sum0;
  logic [iig_pkg::SUM_W-1:0]      sum1;
  logic [iig_pkg::SUM_W-1:0]      sum2;
  logic                           frame_last;

  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [iig_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [iig_pkg::SIZE_W-1:0]     cfg_data    = '0;

  integral_image_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .chan0       (chan0),
    .chan1       (chan1),
    .chan2       (chan2),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sum0        (sum0),
    .sum1        (sum1),
    .sum2        (sum2),
    .frame_last  (frame_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // integral predictor: own copy of size registers, scan position, row sums and
  // the previous-row line store
  // ---------------------------------------------------------------------------
  logic [iig_pkg::SIZE_W-1:0] width_reg  = iig_pkg::FRAME_WIDTH_RESET;
  logic [iig_pkg::SIZE_W-1:0] height_reg = iig_pkg::FRAME_HEIGHT_RESET;
  int                         scan_col   = 0;
  int                         scan_row   = 0;
  iig_pkg::run_t              row_acc   [iig_pkg::NUM_CH];
  iig_pkg::sum_t              line_mem  [iig_pkg::NUM_CH][iig_pkg::MAX_WIDTH];
  // which columns of the line store hold a value since reset
  bit                         line_seen [iig_pkg::MAX_WIDTH];

  // expected results in transfer order
  iig_pkg::result_t sum_expect [$];
  int               mismatches = 0;

  // traffic shaping, written by the stimulus process only
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_token   = 0;

  // zero behaves as one, anything past the maximum as the maximum
  function automatic int effective_size(logic [iig_pkg::SIZE_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // true when this pixel would land on a lower row at a column never stored
  function automatic bit reads_unwritten(logic fs);
    int col;
    int row;
    col = fs ? 0 : scan_col;
    row = fs ? 0 : scan_row;
    if (col >= iig_pkg::MAX_WIDTH) col = iig_pkg::MAX_WIDTH - 1;
    return (row != 0) && !line_seen[col];
  endfunction

  function automatic iig_pkg::result_t integrate_pixel(iig_pkg::pix_vec_t px, logic fs);
    iig_pkg::result_t r;
    int               w;
    int               h;
    int               col;
    int               row;
    iig_pkg::sum_t    s;
    logic             row_end;
    w = effective_size(width_reg, iig_pkg::MAX_WIDTH);
    h = effective_size(height_reg, iig_pkg::MAX_HEIGHT);
    if (fs) begin
      scan_col = 0;
      scan_row = 0;
    end
    col = scan_col;
    row = scan_row;
    if (col >= iig_pkg::MAX_WIDTH) col = iig_pkg::MAX_WIDTH - 1;
    for (int c = 0; c < iig_pkg::NUM_CH; c++) begin
      if (col == 0) row_acc[c] = '0;
      row_acc[c] = row_acc[c] + iig_pkg::RUN_W'(px[c]);
      s = iig_pkg::SUM_W'(row_acc[c]);
      if (row != 0) s = s + line_mem[c][col];
      line_mem[c][col] = s;
      r.sum[c] = s;
    end
    line_seen[col] = 1'b1;
    row_end = (col + 1 >= w);
    r.last  = row_end && (row + 1 >= h);
    if (row_end) begin
      scan_col = 0;
      scan_row = r.last ? 0 : row + 1;
    end else begin
      scan_col = col + 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan rows
  // ---------------------------------------------------------------------------
  plan_step_t directed_plan [$];

  function automatic void plan_add(plan_step_t st);
    directed_plan.insert(directed_plan.size(), st);
  endfunction

  function automatic plan_step_t pixel_step(int c0, int c1, int c2, logic fs);
    plan_step_t st;
    st.kind    = STEP_PIXEL;
    st.reg_idx = '0;
    st.reg_val = '0;
    st.px[0]   = iig_pkg::PIX_W'(c0);
    st.px[1]   = iig_pkg::PIX_W'(c1);
    st.px[2]   = iig_pkg::PIX_W'(c2);
    st.fs      = fs;
    st.typed   = 1'b0;
    st.want    = '0;
    return st;
  endfunction

  // pixel whose result is obvious: typed in rather than predicted
  function automatic plan_step_t known_step(int c0, int c1, int c2, logic fs,
                                            int s0, int s1, int s2, logic last);
    plan_step_t st;
    st             = pixel_step(c0, c1, c2, fs);
    st.typed       = 1'b1;
    st.want.sum[0] = iig_pkg::SUM_W'(s0);
    st.want.sum[1] = iig_pkg::SUM_W'(s1);
    st.want.sum[2] = iig_pkg::SUM_W'(s2);
    st.want.last   = last;
    return st;
  endfunction

  function automatic plan_step_t reg_step(logic [iig_pkg::CFG_IDX_W-1:0] idx, int val);
    plan_step_t st;
    st         = pixel_step(0, 0, 0, 1'b0);
    st.kind    = STEP_REG;
    st.reg_idx = idx;
    st.reg_val = iig_pkg::SIZE_W'(val);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one pixel, hold it through stalls, predict it once it transfers
  task automatic send_pixel(input iig_pkg::pix_vec_t px, input logic fs,
                            input logic typed, input iig_pkg::result_t want);
    iig_pkg::result_t got;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    chan0       <= px[0];
    chan1       <= px[1];
    chan2       <= px[2];
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    got = integrate_pixel(px, fs);
    sum_expect.insert(sum_expect.size(), typed ? want : got);
  endtask

  // sender pauses until every result is out, then the pipe settles
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sum_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [iig_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iig_pkg::SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == iig_pkg::REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus a long hold-off whenever the token moves
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [iig_pkg::SUM_W-1:0] want,
                             input logic [iig_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    iig_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sum_expect.size() == 0) begin
        $error("result transfer with nothing pending: sum0 %0d", sum0);
        mismatches++;
      end else begin
        want = sum_expect.pop_front();
        check_field("sum0", want.sum[0], sum0);
        check_field("sum1", want.sum[1], sum1);
        check_field("sum2", want.sum[2], sum2);
        check_field("frame_last", iig_pkg::SUM_W'(want.last),
                    iig_pkg::SUM_W'(frame_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any transfer on any channel counts as progress
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    iig_pkg::pix_vec_t          px;
    logic                       fs;
    logic                       depth_only;
    logic [iig_pkg::SIZE_W-1:0] w_val;
    logic [iig_pkg::SIZE_W-1:0] h_val;
    int                         seg_len;
    int                         pick;
    iig_pkg::result_t           no_value;

    no_value = '0;
    for (int c = 0; c < iig_pkg::NUM_CH; c++) row_acc[c] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the size is 640 x 480; row 0 sums are plain running sums
    plan_add(known_step(255, 0, 128, 1'b1, 255, 0, 128, 1'b0));
    plan_add(known_step(0, 255, 1, 1'b0, 255, 255, 129, 1'b0));
    plan_add(pixel_step(8'h55, 8'hAA, 8'h0F, 1'b0));
    // frame start in the middle of a row restarts at the origin
    plan_add(known_step(10, 20, 30, 1'b1, 10, 20, 30, 1'b0));
    // zero sizes act as one; the first pixel after shrinking closes the frame
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, 0));
    plan_add(reg_step(iig_pkg::REG_FRAME_HEIGHT, 0));
    plan_add(pixel_step(128, 64, 32, 1'b0));
    plan_add(known_step(255, 255, 255, 1'b0, 255, 255, 255, 1'b1));
    plan_add(known_step(0, 0, 0, 1'b1, 0, 0, 0, 1'b1));
    // 2 x 2 frame, then the next frame starts by wrapping
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, 2));
    plan_add(reg_step(iig_pkg::REG_FRAME_HEIGHT, 2));
    plan_add(known_step(1, 2, 3, 1'b0, 1, 2, 3, 1'b0));
    plan_add(known_step(4, 5, 6, 1'b0, 5, 7, 9, 1'b0));
    plan_add(pixel_step(7, 8, 9, 1'b0));
    plan_add(pixel_step(10, 11, 12, 1'b0));
    plan_add(known_step(255, 255, 255, 1'b0, 255, 255, 255, 1'b0));
    // widen mid-frame: the row goes on to the new width
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, 3));
    plan_add(pixel_step(8'hF0, 8'h0F, 8'hFF, 1'b0));
    plan_add(pixel_step(8'h80, 8'h01, 8'h7F, 1'b0));
    plan_add(pixel_step(8'hFE, 8'hFD, 8'hFB, 1'b0));
    plan_add(pixel_step(8'h01, 8'h02, 8'h04, 1'b0));
    plan_add(pixel_step(255, 255, 255, 1'b0));
    // maximum width, height above range
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, iig_pkg::MAX_WIDTH));
    plan_add(reg_step(iig_pkg::REG_FRAME_HEIGHT, 2047));
    plan_add(pixel_step(8'h08, 8'h10, 8'h20, 1'b0));
    plan_add(pixel_step(8'hF7, 8'hEF, 8'hDF, 1'b0));
    plan_add(pixel_step(8'h40, 8'hBF, 8'h00, 1'b0));
    plan_add(pixel_step(255, 0, 255, 1'b0));
    // shrink so the position is already past the last column
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, 2));
    plan_add(pixel_step(3, 3, 3, 1'b0));
    plan_add(pixel_step(200, 100, 50, 1'b0));
    // width above range, single-row height with the position on row one
    plan_add(reg_step(iig_pkg::REG_FRAME_WIDTH, 2047));
    plan_add(reg_step(iig_pkg::REG_FRAME_HEIGHT, 1));
    plan_add(pixel_step(9, 0, 0, 1'b0));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_REG) begin
        drain_results();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_pixel(directed_plan[i].px, directed_plan[i].fs,
                   directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // random part: three traffic phases, each split into segments with their own
    // frame size; sizes are mostly small so frames close and rows stack up
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          in_idle_pct  = 30;
          out_idle_pct = 85;
        end
        1: begin
          in_idle_pct  = 85;
          out_idle_pct = 30;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain_results();
        pick = $urandom_range(9);
        unique case (pick)
          0:       w_val = '0;
          1:       w_val = iig_pkg::SIZE_W'(iig_pkg::MAX_WIDTH);
          2:       w_val = '1;
          3:       w_val = iig_pkg::SIZE_W'(iig_pkg::MAX_WIDTH - 1);
          default: w_val = iig_pkg::SIZE_W'($urandom_range(1, 8));
        endcase
        pick = $urandom_range(9);
        unique case (pick)
          0:       h_val = '0;
          1:       h_val = '1;
          2:       h_val = iig_pkg::SIZE_W'(iig_pkg::MAX_HEIGHT);
          default: h_val = iig_pkg::SIZE_W'($urandom_range(1, 6));
        endcase
        write_reg(iig_pkg::REG_FRAME_WIDTH, w_val);
        write_reg(iig_pkg::REG_FRAME_HEIGHT, h_val);
        // long receiver hold-off while pixels keep coming: fills the queue
        if (phase == 2 && seg == 0) hold_token++;
        depth_only = ($urandom_range(4) == 0);
        seg_len    = $urandom_range(28, 38);
        for (int n = 0; n < seg_len; n++) begin
          pick = $urandom_range(19);
          unique case (pick)
            0:       px = '1;
            1:       px = '0;
            default: begin
              px[0] = iig_pkg::PIX_W'($urandom_range(255));
              px[1] = iig_pkg::PIX_W'($urandom_range(255));
              px[2] = iig_pkg::PIX_W'($urandom_range(255));
            end
          endcase
          if (depth_only) begin
            px[1] = '0;
            px[2] = '0;
          end
          // mostly clean frames; occasional restarts mid-frame
          if (n == 0) fs = $urandom_range(1);
          else fs = ($urandom_range(99) < 4);
          // never step onto a line-store column that holds nothing yet
          if (reads_unwritten(fs)) fs = 1'b1;
          send_pixel(px, fs, 1'b0, no_value);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: integral_image_generator.f
design/iig_pkg.sv
design/iig_ram.sv
design/iig_scan.sv
design/iig_queue.sv
design/integral_image_generator.sv
sim/tb_integral_image_generator.sv
